// ===== rtl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions of the text console character writer
// Geometry, character and mode codes, the cell word layout and the cursor
// update record passed between the cursor logic and the sequencer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Screen and history geometry.
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 24;
  localparam int HISTORY_ROWS = 256;
  localparam int TAB_WIDTH    = 8;   // tab stops are taken as a power of two
  localparam int CELL_COUNT   = HISTORY_ROWS * COLUMNS;

  localparam int COL_W  = 7;   // holds 0..COLUMNS, COLUMNS meaning wrap pending
  localparam int ROW_W  = 5;
  localparam int RING_W = 8;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CHAR_W = 8;
  localparam int COLR_W = 32;
  localparam int CELL_W = CHAR_W + 2 * COLR_W;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Request modes.
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_TEXT_COLOUR = 1'b0;
  localparam logic CFG_BACK_COLOUR = 1'b1;

  localparam logic [COLR_W-1:0] TEXT_COLOUR_RESET = 32'hFFD4D4D4;
  localparam logic [COLR_W-1:0] BACK_COLOUR_RESET = 32'h0000_0000;

  // Result of one character on the cursor.
  typedef struct packed {
    logic [COL_W-1:0] col;      // cursor column afterwards
    logic [ROW_W-1:0] row;      // cursor row afterwards (also the row written)
    logic             scroll;   // the window moves up by one row
    logic             put;      // a printable character is stored
    logic [COL_W-1:0] put_col;  // column the character is stored at
  } cur_upd_t;

endpackage

// ===== rtl/tccw_ram.sv =====
// ----------------------------------------------------------------------------
// tccw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data; the read data
// holds while no read is enabled.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tccw_cursor.sv =====
// ----------------------------------------------------------------------------
// tccw_cursor: cursor movement for one character
// Works out the new cursor position, whether the window scrolls, and where a
// printable character lands.
// ----------------------------------------------------------------------------
module tccw_cursor
  import tccw_pkg::*;
(
  input  logic [COL_W-1:0]  cur_col,
  input  logic [ROW_W-1:0]  cur_row,
  input  logic [CHAR_W-1:0] char_code,
  output cur_upd_t          upd
);

  logic             at_bottom;
  logic [ROW_W-1:0] nl_row;
  logic [COL_W:0]   tab_stop;

  // Going to the next line either steps the row or scrolls at the bottom.
  assign at_bottom = (cur_row == ROW_W'(ROWS - 1));
  assign nl_row    = at_bottom ? cur_row : cur_row + ROW_W'(1);
  assign tab_stop  = (COL_W+1)'(cur_col) - (COL_W+1)'(cur_col % TAB_WIDTH)
                   + (COL_W+1)'(TAB_WIDTH);

  always_comb begin
    upd         = '0;
    upd.col     = cur_col;
    upd.row     = cur_row;
    upd.put_col = cur_col;
    case (char_code)
      CH_LF: begin
        upd.col    = '0;
        upd.row    = nl_row;
        upd.scroll = at_bottom;
      end
      CH_CR: begin
        upd.col = '0;
      end
      CH_TAB: begin
        if (tab_stop >= (COL_W+1)'(COLUMNS)) begin
          upd.col    = '0;
          upd.row    = nl_row;
          upd.scroll = at_bottom;
        end else begin
          upd.col = tab_stop[COL_W-1:0];
        end
      end
      CH_BS: begin
        if (cur_col != '0) begin
          upd.col = cur_col - COL_W'(1);
        end
      end
      default: begin
        upd.put = 1'b1;
        if (cur_col >= COL_W'(COLUMNS)) begin
          // Pending wrap: the character goes to column 0 of the next line.
          upd.put_col = '0;
          upd.row     = nl_row;
          upd.scroll  = at_bottom;
        end
        upd.col = upd.put_col + COL_W'(1);
      end
    endcase
  end

endmodule

// ===== rtl/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer: 80 by 24 text console over a ring of 256 rows
// Takes character, clear and read requests, keeps the cursor and the ring
// head, and holds every cell (character and two colours) in one RAM.
// ----------------------------------------------------------------------------
//
//   channel  direction  contents
//   in_      request    tuser: mode; tdata: char_code, read_row, read_col
//   out_     result     tdata: cursor, top row, scroll flag, read cell
//   cfg_     write      text_colour (index 0), back_colour (index 1)
//
// A request that only moves the cursor or stores one character writes any
// cell in the accept cycle and then loads the result register. A read is
// taken into the registered RAM read port, and the result register takes the
// cell from its output. A scroll adds a sweep that blanks the new bottom row
// (80 cells); a clear sweeps 24 * 80 = 1920 cells, one cell write per cycle on
// the single RAM write port. After reset a clearing pass writes all 20480
// cells, one per cycle, before the first request is taken; configuration
// writes are taken during it. The request side is free again as soon as the
// result sits in the output register, so a stalled result does not hold
// the next request back; only a second result waits for the register.
//
// The ring rows are contiguous in the RAM, so every sweep (blanking a row,
// clearing the screen or the initial pass) is a linear address run that
// wraps at the end of the store.
// ----------------------------------------------------------------------------
module text_console_char_writer
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // cursor_col[6:0], cursor_row[11:7], top_row[19:12],
                                  // did_scroll[20], cell_char[28:21], cell_fore[60:29],
                                  // cell_back[92:61]
  // Configuration port.
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Sequencer states.
  localparam logic [1:0] ST_INIT  = 2'd0;  // clearing pass after reset
  localparam logic [1:0] ST_IDLE  = 2'd1;  // ready for a request
  localparam logic [1:0] ST_SWEEP = 2'd2;  // blanking a run of cells
  localparam logic [1:0] ST_DONE  = 2'd3;  // result waits for the output register

  // Ring index of a row some distance below a given ring row.
  function automatic logic [RING_W-1:0] ring_add(input logic [RING_W-1:0] base,
                                                 input logic [RING_W-1:0] off);
    logic [RING_W:0] sum;
    sum = (RING_W+1)'(base) + (RING_W+1)'(off);
    if (sum >= (RING_W+1)'(HISTORY_ROWS)) begin
      sum = sum - (RING_W+1)'(HISTORY_ROWS);
    end
    return sum[RING_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [RING_W-1:0] ring,
                                                  input logic [COL_W-1:0]  col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ring) * ADDR_W'(COLUMNS);
    return base + ADDR_W'(col);
  endfunction

  // Request fields.
  logic [1:0]        req_mode;
  logic [CHAR_W-1:0] req_char;
  logic [ROW_W-1:0]  req_row;
  logic [COL_W-1:0]  req_col;

  assign req_mode = in_tuser;
  assign req_char = in_tdata[7:0];
  assign req_row  = in_tdata[12:8];
  assign req_col  = in_tdata[19:13];

  // State.
  logic [1:0]        state_r, state_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [RING_W-1:0] head_r, head_nxt;
  logic [COLR_W-1:0] text_colour_r, back_colour_r;
  logic [ADDR_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [ADDR_W-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic              pend_put_r, pend_put_nxt;
  logic [CHAR_W-1:0] pend_char_r, pend_char_nxt;
  logic              scroll_r, scroll_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  // Output register.
  logic              out_valid_r;
  logic [95:0]       out_data_r;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  cur_upd_t          upd;
  logic              accept;
  logic              out_load;
  logic [RING_W-1:0] put_ring;
  logic [CHAR_W-1:0] sweep_char;

  tccw_cursor u_cursor (
    .cur_col   (cur_col_r),
    .cur_row   (cur_row_r),
    .char_code (req_char),
    .upd       (upd)
  );

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign put_ring  = ring_add(head_r, RING_W'(upd.row));

  // The first cell of a scroll sweep is column 0 of the new bottom row, where
  // a wrapped printable character lands.
  assign sweep_char = pend_put_r ? pend_char_r : CH_SPACE;

  // The read address is only meaningful for an in-range cell.
  assign ram_re    = accept && (req_mode == MODE_READ);
  assign ram_raddr = cell_addr(ring_add(head_r, RING_W'(req_row)), req_col);

  always_comb begin
    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    head_nxt       = head_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    pend_put_nxt   = pend_put_r;
    pend_char_nxt  = pend_char_r;
    scroll_nxt     = scroll_r;
    rd_ok_nxt      = rd_ok_r;
    ram_we         = 1'b0;
    ram_waddr      = sweep_addr_r;
    ram_wdata      = {back_colour_r, text_colour_r, sweep_char};

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {BACK_COLOUR_RESET, TEXT_COLOUR_RESET, CH_SPACE};
      end
      ST_SWEEP: begin
        ram_we       = 1'b1;
        pend_put_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    // Sweep address and count advance in both sweeping states.
    if (state_r == ST_INIT || state_r == ST_SWEEP) begin
      if (sweep_addr_r == ADDR_W'(CELL_COUNT - 1)) begin
        sweep_addr_nxt = '0;
      end else begin
        sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);
      end
      sweep_cnt_nxt = sweep_cnt_r - ADDR_W'(1);
      if (sweep_cnt_r == '0) begin
        state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
      end
    end

    if (accept) begin
      scroll_nxt   = 1'b0;
      rd_ok_nxt    = 1'b0;
      pend_put_nxt = 1'b0;
      state_nxt    = ST_DONE;
      case (req_mode)
        MODE_PUT: begin
          cur_col_nxt   = upd.col;
          cur_row_nxt   = upd.row;
          scroll_nxt    = upd.scroll;
          pend_char_nxt = req_char;
          if (upd.scroll) begin
            // New bottom row sits ROWS rows below the old head.
            head_nxt       = (head_r == RING_W'(HISTORY_ROWS - 1)) ? '0
                                                                   : head_r + RING_W'(1);
            sweep_addr_nxt = cell_addr(ring_add(head_r, RING_W'(ROWS)), '0);
            sweep_cnt_nxt  = ADDR_W'(COLUMNS - 1);
            pend_put_nxt   = upd.put;
            state_nxt      = ST_SWEEP;
          end else if (upd.put) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(put_ring, upd.put_col);
            ram_wdata = {back_colour_r, text_colour_r, req_char};
          end
        end
        MODE_CLEAR: begin
          cur_col_nxt    = '0;
          cur_row_nxt    = '0;
          sweep_addr_nxt = cell_addr(head_r, '0);
          sweep_cnt_nxt  = ADDR_W'(ROWS * COLUMNS - 1);
          state_nxt      = ST_SWEEP;
        end
        MODE_READ: begin
          rd_ok_nxt = (req_row < ROW_W'(ROWS)) && (req_col < COL_W'(COLUMNS));
        end
        default: begin
        end
      endcase
    end

    if (out_load) begin
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      head_r        <= '0;
      text_colour_r <= TEXT_COLOUR_RESET;
      back_colour_r <= BACK_COLOUR_RESET;
      sweep_addr_r  <= '0;
      sweep_cnt_r   <= ADDR_W'(CELL_COUNT - 1);
      pend_put_r    <= 1'b0;
      scroll_r      <= 1'b0;
      rd_ok_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      head_r       <= head_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      pend_put_r   <= pend_put_nxt;
      scroll_r     <= scroll_nxt;
      rd_ok_r      <= rd_ok_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TEXT_COLOUR: text_colour_r <= cfg_wdata;
          CFG_BACK_COLOUR: back_colour_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; the read data stays in the RAM output until the next read.
  always_ff @(posedge clk) begin
    pend_char_r <= pend_char_nxt;
    if (out_load) begin
      out_data_r <= {3'b000,
                     rd_ok_r ? ram_rdata : {CELL_W{1'b0}},
                     scroll_r, head_r, cur_row_r, cur_col_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // An accepted request always takes the sequencer out of the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // A new result only appears after a finished request.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised without a finished request");

  // The cursor stays inside the window, with column COLUMNS as pending wrap.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r < ROW_W'(ROWS)) && (cur_col_r <= COL_W'(COLUMNS)))
    else $error("cursor outside the window");

  // The last cell of a request sweep hands over to the result stage.
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && sweep_cnt_r == '0) |=> (state_r == ST_DONE))
    else $error("sweep did not finish into the result stage");

  // While idle the cell store is only written by an accepted character.
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && ram_we) |-> (accept && req_mode == MODE_PUT))
    else $error("cell write while idle without a character request");
`endif

endmodule
